/* rtl/core/etae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etae_pkg
// Shared types and constants for the echo TTL address encoder: protocol
// codes, the classified command and the layout of one table entry.
// ----------------------------------------------------------------------------
package etae_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;

	localparam logic [7:0] ICMP_PROTOCOL = 8'd1;
	localparam logic [7:0] TYPE_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_ECHO     = 8'd8;
	localparam logic [7:0] TYPE_ECHO_ALT = 8'd69;
	localparam logic [7:0] TTL_CAP       = 8'd64;

	typedef enum logic [1:0] {
		KIND_PASS    = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_REQUEST = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [7:0]  ttl;
		logic [15:0] csum;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [6:0]  ttl;
		logic [1:0]  pos;
		logic [31:0] stamp;
	} entry_t;

	// Handshake between the command queue and the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

/* rtl/core/etae_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/etae_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etae_front
// Accepts header items, classifies them as echo reply, echo request or
// pass-through, and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module etae_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         ip_protocol,
	input  logic [7:0]         icmp_type,
	input  logic [31:0]        source_address,
	input  logic [31:0]        dest_address,
	input  logic [7:0]         ttl_in,
	input  logic [15:0]        checksum_in,
	input  logic [31:0]        now_seconds,
	output etae_pkg::cmd_chan_t cmd_out,
	input  logic               cmd_pop
);

	etae_pkg::cmd_t  slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	etae_pkg::kind_t kind;
	etae_pkg::cmd_t  cmd_new;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		kind = etae_pkg::KIND_PASS;
		if (ip_protocol == etae_pkg::ICMP_PROTOCOL) begin
			if (icmp_type == etae_pkg::TYPE_REPLY) begin
				kind = etae_pkg::KIND_REPLY;
			end else if (icmp_type == etae_pkg::TYPE_ECHO ||
			             icmp_type == etae_pkg::TYPE_ECHO_ALT) begin
				kind = etae_pkg::KIND_REQUEST;
			end
		end
		cmd_new.kind  = kind;
		cmd_new.saddr = source_address;
		cmd_new.daddr = dest_address;
		cmd_new.ttl   = ttl_in;
		cmd_new.csum  = checksum_in;
		cmd_new.now   = now_seconds;
	end

	assign full          = (count_q == 2'd2);
	assign do_push       = push && !full;
	assign do_pop        = cmd_pop && (count_q != 2'd0);
	assign cmd_out.valid = (count_q != 2'd0);
	assign cmd_out.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/etae_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etae_back
// Carries out classified commands: scans the address table one entry a
// cycle, records echo requests, rewrites the TTL of matching replies with
// an incremental checksum update, and holds the result in an output register.
// ----------------------------------------------------------------------------
module etae_back #(
	parameter int TABLE_ENTRIES = etae_pkg::TABLE_ENTRIES_DEF,
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  etae_pkg::cmd_chan_t cmd_in,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output logic                ttl_rewritten,
	output logic [7:0]          ttl_out,
	output logic [15:0]         checksum_out
);

	localparam int EW = $bits(etae_pkg::entry_t);
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t               state_q;
	etae_pkg::cmd_t       cur_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IW-1:0]        scan_idx_q;
	logic                 issue_on_q;
	logic                 have_data_q;
	logic [IW-1:0]        chk_idx_q;
	logic [31:0]          oldest_q;
	logic [IW-1:0]        pick_idx_q;
	logic [1:0]           pick_pos_q;
	logic                 write_q;
	logic [IW-1:0]        sel_idx_q;
	etae_pkg::entry_t     wr_entry_q;
	logic                 res_rw_q;
	logic [7:0]           res_ttl_q;
	logic                 out_valid_q;
	logic                 out_rw_q;
	logic [7:0]           out_ttl_q;
	logic [15:0]          out_csum_q;

	logic [EW-1:0]        ram_rdata;
	etae_pkg::entry_t     ent;
	logic                 is_reply;
	logic                 hit;
	logic                 last;
	logic                 pick_now;
	logic [7:0]           octet;
	logic [7:0]           ttl_calc;
	logic [6:0]           ttl_clamp;
	logic                 load;
	logic                 ram_we;
	logic [15:0]          old_word;
	logic [15:0]          new_word;
	logic [17:0]          sum;
	logic [16:0]          fold1;
	logic [16:0]          fold2;
	logic [15:0]          csum_new;

	etae_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sel_idx_q),
		.wdata(wr_entry_q),
		.re   (state_q == S_SCAN && issue_on_q),
		.raddr(scan_idx_q),
		.rdata(ram_rdata)
	);

	// An entry never written reads as empty
	assign ent      = valid_q[chk_idx_q] ? etae_pkg::entry_t'(ram_rdata) : '0;
	assign is_reply = (cur_q.kind == etae_pkg::KIND_REPLY);
	assign hit      = have_data_q && (is_reply ? (ent.addr == cur_q.daddr)
	                  : (ent.addr == 32'd0 || ent.addr == cur_q.saddr));
	assign last     = have_data_q && (chk_idx_q == LAST);
	assign pick_now = (chk_idx_q == '0) || (ent.stamp < oldest_q);

	always_comb begin
		case (ent.pos)
			2'd0:    octet = cur_q.daddr[7:0];
			2'd1:    octet = cur_q.daddr[15:8];
			2'd2:    octet = cur_q.daddr[23:16];
			default: octet = cur_q.daddr[31:24];
		endcase
	end

	assign ttl_calc  = octet + etae_pkg::TTL_CAP - {1'b0, ent.ttl};
	assign ttl_clamp = (cur_q.ttl > etae_pkg::TTL_CAP) ? etae_pkg::TTL_CAP[6:0]
	                   : cur_q.ttl[6:0];

	// One's-complement update of the TTL/protocol word
	assign old_word = {cur_q.ttl, etae_pkg::ICMP_PROTOCOL};
	assign new_word = {res_ttl_q, etae_pkg::ICMP_PROTOCOL};
	assign sum      = {2'b00, ~cur_q.csum} + {2'b00, ~old_word} + {2'b00, new_word};
	assign fold1    = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
	assign fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
	assign csum_new = ~fold2[15:0];

	assign load    = (state_q == S_DONE) && (!out_valid_q || pop);
	assign ram_we  = load && write_q;
	assign cmd_pop = (state_q == S_IDLE) && cmd_in.valid;

	assign empty         = !out_valid_q;
	assign ttl_rewritten = out_rw_q;
	assign ttl_out       = out_ttl_q;
	assign checksum_out  = out_csum_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q     <= cmd_in.cmd;
			write_q   <= 1'b0;
			res_rw_q  <= 1'b0;
			res_ttl_q <= cmd_in.cmd.ttl;
		end
		if (state_q == S_SCAN) begin
			chk_idx_q <= scan_idx_q;
			if (have_data_q && !hit && !is_reply && pick_now) begin
				oldest_q   <= ent.stamp;
				pick_idx_q <= chk_idx_q;
				pick_pos_q <= ent.pos;
			end
			if (hit || last) begin
				if (is_reply) begin
					write_q          <= hit;
					res_rw_q         <= hit;
					res_ttl_q        <= hit ? ttl_calc : cur_q.ttl;
					sel_idx_q        <= chk_idx_q;
					wr_entry_q.addr  <= ent.addr;
					wr_entry_q.ttl   <= ent.ttl;
					wr_entry_q.pos   <= ent.pos + 2'd1;
					wr_entry_q.stamp <= ent.stamp;
				end else begin
					write_q          <= 1'b1;
					res_rw_q         <= 1'b0;
					res_ttl_q        <= cur_q.ttl;
					wr_entry_q.addr  <= cur_q.saddr;
					wr_entry_q.ttl   <= ttl_clamp;
					wr_entry_q.stamp <= cur_q.now;
					if (hit || pick_now) begin
						sel_idx_q      <= chk_idx_q;
						wr_entry_q.pos <= ent.pos;
					end else begin
						sel_idx_q      <= pick_idx_q;
						wr_entry_q.pos <= pick_pos_q;
					end
				end
			end
		end
		if (load) begin
			out_rw_q   <= res_rw_q;
			out_ttl_q  <= res_ttl_q;
			out_csum_q <= res_rw_q ? csum_new : cur_q.csum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			scan_idx_q  <= '0;
			issue_on_q  <= 1'b0;
			have_data_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[sel_idx_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						scan_idx_q  <= '0;
						issue_on_q  <= 1'b1;
						have_data_q <= 1'b0;
						state_q     <= (cmd_in.cmd.kind == etae_pkg::KIND_PASS)
						               ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					// drop any read still in flight once the entry is settled
					if (hit || last) begin
						issue_on_q  <= 1'b0;
						have_data_q <= 1'b0;
						state_q     <= S_DONE;
					end else begin
						have_data_q <= issue_on_q;
						if (issue_on_q) begin
							if (scan_idx_q == LAST) begin
								issue_on_q <= 1'b0;
							end else begin
								scan_idx_q <= scan_idx_q + 1'b1;
							end
						end
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/echo_ttl_address_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_ttl_address_encoder
// Records the source of ICMP echo requests and rewrites the TTL of echo
// replies to recorded addresses, updating the header checksum.
// ----------------------------------------------------------------------------
//  channel  handshake          fields
//  input    push / full        ip_protocol icmp_type source_address
//                              dest_address ttl_in checksum_in now_seconds
//  result   pop / empty        ttl_rewritten ttl_out checksum_out
//
// A pass-through item skips the table scan in the back end. An echo request
// or reply scans the table one entry a cycle through the single read port of
// the table RAM, stopping at the first matching entry. Reset clears the
// per-entry valid bits at once; no clearing pass is needed. A two-entry
// command queue keeps input accepts going while the back end scans, and the
// output register frees the back end while a result waits to be popped.
// ----------------------------------------------------------------------------
module echo_ttl_address_encoder #(
	parameter int TABLE_ENTRIES = etae_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ip_protocol,
	input  logic [7:0]  icmp_type,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [7:0]  ttl_in,
	input  logic [15:0] checksum_in,
	input  logic [31:0] now_seconds,
	output logic        empty,
	input  logic        pop,
	output logic        ttl_rewritten,
	output logic [7:0]  ttl_out,
	output logic [15:0] checksum_out
);

	etae_pkg::cmd_chan_t cmd_chan;
	logic                cmd_pop;

	etae_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.ip_protocol   (ip_protocol),
		.icmp_type     (icmp_type),
		.source_address(source_address),
		.dest_address  (dest_address),
		.ttl_in        (ttl_in),
		.checksum_in   (checksum_in),
		.now_seconds   (now_seconds),
		.cmd_out       (cmd_chan),
		.cmd_pop       (cmd_pop)
	);

	etae_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_in       (cmd_chan),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.ttl_rewritten(ttl_rewritten),
		.ttl_out      (ttl_out),
		.checksum_out (checksum_out)
	);

endmodule

/* bench/tb_echo_ttl_address_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_ttl_address_encoder
// Self-checking bench for the echo TTL address encoder. A queue-fed driver
// offers header summaries with random gaps, and a receiver pops results with
// random stalls. Every accepted item runs through a local model of the echo
// table, and the model's TTL and checksum are compared with each result in
// order. A directed opening covers pass-through, clamping, octet rotation and
// the zero address. Random traffic then drives a pool of addresses larger
// than the table, so eviction by oldest stamp is reached.
// ----------------------------------------------------------------------------
module tb_echo_ttl_address_encoder;

	localparam int TABLE_ENTRIES = etae_pkg::TABLE_ENTRIES_DEF;
	localparam logic [7:0] ICMP_PROTOCOL = etae_pkg::ICMP_PROTOCOL;
	localparam logic [7:0] TYPE_REPLY    = etae_pkg::TYPE_REPLY;
	localparam logic [7:0] TYPE_ECHO     = etae_pkg::TYPE_ECHO;
	localparam logic [7:0] TYPE_ECHO_ALT = etae_pkg::TYPE_ECHO_ALT;
	localparam logic [7:0] TTL_CAP       = etae_pkg::TTL_CAP;
	localparam int N_RANDOM      = 1830;
	localparam int POOL_SIZE     = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 64;
	localparam int HOLD_CYCLES   = 250;
	localparam logic [7:0] TYPE_UNREACHABLE = 8'd3;

	typedef struct packed {
		logic [7:0]  proto;
		logic [7:0]  icmp;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  ttl;
		logic [15:0] csum;
		logic [31:0] now;
	} hdr_t;

	typedef struct packed {
		logic        rewritten;
		logic [7:0]  ttl;
		logic [15:0] csum;
	} rewrite_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  ip_protocol = '0;
	logic [7:0]  icmp_type = '0;
	logic [31:0] source_address = '0;
	logic [31:0] dest_address = '0;
	logic [7:0]  ttl_in = '0;
	logic [15:0] checksum_in = '0;
	logic [31:0] now_seconds = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        ttl_rewritten;
	logic [7:0]  ttl_out;
	logic [15:0] checksum_out;

	// echo table copy
	logic [31:0] rec_addr  [TABLE_ENTRIES];
	logic [6:0]  rec_ttl   [TABLE_ENTRIES];
	logic [1:0]  rec_pos   [TABLE_ENTRIES];
	logic [31:0] rec_stamp [TABLE_ENTRIES];

	hdr_t     pending_headers [$];
	rewrite_t expected_rewrites [$];
	hdr_t     next_hdr;
	hdr_t     seen_hdr;
	rewrite_t due;

	logic tx_taken = 1'b0;
	logic rx_taken = 1'b0;
	logic rx_hold = 1'b0;
	logic gapless = 1'b0;
	int   tx_gap = 0;
	int   rx_gap = 0;
	int   n_accepted = 0;
	int   cycle_count = 0;
	int   errors = 0;

	echo_ttl_address_encoder #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ip_protocol(ip_protocol),
		.icmp_type(icmp_type),
		.source_address(source_address),
		.dest_address(dest_address),
		.ttl_in(ttl_in),
		.checksum_in(checksum_in),
		.now_seconds(now_seconds),
		.empty(empty),
		.pop(pop),
		.ttl_rewritten(ttl_rewritten),
		.ttl_out(ttl_out),
		.checksum_out(checksum_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gapless || rx_hold || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Update the echo table for one header and return the rewritten fields
	function automatic rewrite_t encode_echo_ttl(input hdr_t h);
		rewrite_t    r;
		int          idx;
		int          oldest_idx;
		logic        found;
		logic [31:0] oldest;
		logic [1:0]  pos;
		logic [7:0]  octet;
		logic [17:0] acc;
		r.rewritten = 1'b0;
		r.ttl = h.ttl;
		r.csum = h.csum;
		found = 1'b0;
		if (h.proto == ICMP_PROTOCOL && h.icmp == TYPE_REPLY) begin
			for (idx = 0; idx < TABLE_ENTRIES && !found; idx++) begin
				if (rec_addr[idx] == h.dst) begin
					found = 1'b1;
					pos = rec_pos[idx];
					octet = h.dst[8*pos +: 8];
					r.ttl = octet + TTL_CAP - {1'b0, rec_ttl[idx]};
					rec_pos[idx] = pos + 2'd1;
				end
			end
			if (found) begin
				r.rewritten = 1'b1;
				// one's-complement update of the TTL/protocol word
				acc = {2'b00, ~h.csum} + {2'b00, ~{h.ttl, h.proto}} + {2'b00, r.ttl, h.proto};
				acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
				acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
				r.csum = ~acc[15:0];
			end
		end else if (h.proto == ICMP_PROTOCOL && (h.icmp == TYPE_ECHO || h.icmp == TYPE_ECHO_ALT)) begin
			oldest_idx = 0;
			oldest = rec_stamp[0];
			idx = 0;
			while (idx < TABLE_ENTRIES && !found) begin
				if (rec_addr[idx] == '0 || rec_addr[idx] == h.src) begin
					found = 1'b1;
				end else begin
					if (rec_stamp[idx] < oldest) begin
						oldest = rec_stamp[idx];
						oldest_idx = idx;
					end
					idx++;
				end
			end
			if (!found)
				idx = oldest_idx;
			rec_addr[idx] = h.src;
			rec_ttl[idx] = (h.ttl > TTL_CAP) ? TTL_CAP[6:0] : h.ttl[6:0];
			rec_stamp[idx] = h.now;
		end
		return r;
	endfunction

	task automatic add_header(input logic [7:0] proto, input logic [7:0] icmp,
			input logic [31:0] src, input logic [31:0] dst, input logic [7:0] ttl,
			input logic [15:0] csum, input logic [31:0] now);
		hdr_t h;
		h.proto = proto;
		h.icmp = icmp;
		h.src = src;
		h.dst = dst;
		h.ttl = ttl;
		h.csum = csum;
		h.now = now;
		pending_headers.push_back(h);
	endtask

	// Driver: present items on the falling edge, hold until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || tx_taken) begin
			if (tx_gap > 0) begin
				push <= 1'b0;
				tx_gap--;
			end else if (pending_headers.size() > 0) begin
				next_hdr = pending_headers.pop_front();
				ip_protocol <= next_hdr.proto;
				icmp_type <= next_hdr.icmp;
				source_address <= next_hdr.src;
				dest_address <= next_hdr.dst;
				ttl_in <= next_hdr.ttl;
				checksum_in <= next_hdr.csum;
				now_seconds <= next_hdr.now;
				push <= 1'b1;
				tx_gap = pick_gap();
				if ($urandom_range(0, 149) == 0)
					gapless <= !gapless;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: pop with random stalls, or hold off entirely on request
	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			pop <= 1'b0;
		end else if (!pop || rx_taken) begin
			if (rx_gap > 0) begin
				pop <= 1'b0;
				rx_gap--;
			end else begin
				pop <= 1'b1;
				rx_gap = pick_gap();
			end
		end
	end

	// Monitor: predict on each accepted item, check each popped result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		tx_taken <= push && !full;
		rx_taken <= pop && !empty;
		if (arst_n && push && !full) begin
			seen_hdr.proto = ip_protocol;
			seen_hdr.icmp = icmp_type;
			seen_hdr.src = source_address;
			seen_hdr.dst = dest_address;
			seen_hdr.ttl = ttl_in;
			seen_hdr.csum = checksum_in;
			seen_hdr.now = now_seconds;
			expected_rewrites.push_back(encode_echo_ttl(seen_hdr));
			n_accepted <= n_accepted + 1;
		end
		if (arst_n && pop && !empty) begin
			if (expected_rewrites.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: rewritten=%0b ttl=%0d checksum=%h",
					$time, ttl_rewritten, ttl_out, checksum_out);
			end else begin
				due = expected_rewrites.pop_front();
				if (ttl_rewritten !== due.rewritten) begin
					errors++;
					$display("%0t: ttl_rewritten expected %0b actual %0b",
						$time, due.rewritten, ttl_rewritten);
				end
				if (ttl_out !== due.ttl) begin
					errors++;
					$display("%0t: ttl_out expected %0d actual %0d", $time, due.ttl, ttl_out);
				end
				if (checksum_out !== due.csum) begin
					errors++;
					$display("%0t: checksum_out expected %h actual %h",
						$time, due.csum, checksum_out);
				end
			end
		end
	end

	// Hold off the receiver twice so the block fills and stalls its input
	initial begin
		int round;
		for (round = 0; round < 2; round++) begin
			while (n_accepted < 400 + 800 * round)
				@(posedge clk);
			rx_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] addr_pool [POOL_SIZE];
		logic [31:0] addr_a;
		logic [31:0] addr_b;
		logic [31:0] addr_c;
		logic [31:0] sim_now;
		hdr_t        h;
		int          n;
		int          roll;

		foreach (rec_addr[i]) begin
			rec_addr[i] = '0;
			rec_ttl[i] = '0;
			rec_pos[i] = '0;
			rec_stamp[i] = '0;
		end
		addr_a = 32'h4433_2211;
		addr_b = 32'h01FF_80FE;
		addr_c = 32'h7F00_00C0;

		// pass-through: not ICMP, other ICMP types, replies with no entry
		add_header(8'h00, TYPE_ECHO, '1, '1, 8'hFF, 16'hFFFF, '1);
		add_header(8'hFF, TYPE_REPLY, '0, '0, 8'h00, 16'h0000, '0);
		add_header(ICMP_PROTOCOL, TYPE_UNREACHABLE, addr_a, addr_a, 8'd64, 16'h1234, 32'd5);
		add_header(ICMP_PROTOCOL, 8'hFF, addr_a, addr_b, 8'd9, 16'h5555, 32'd5);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, '0, addr_b, 8'd100, 16'hBEEF, 32'd6);
		// reply to the zero address hits an empty entry
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_a, '0, 8'd10, 16'h0000, 32'd7);
		// request with TTL above the cap, then rotate through all octets
		add_header(ICMP_PROTOCOL, TYPE_ECHO, addr_a, addr_b, 8'hFF, 16'hFFFF, '1);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_a, 8'h00, 16'h0000, 32'd8);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_a, 8'hFF, 16'hFFFF, 32'd8);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_a, 8'd64, 16'h8000, 32'd9);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_a, 8'd1, 16'h0001, 32'd9);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_a, 8'd128, 16'h7FFF, 32'd9);
		add_header(ICMP_PROTOCOL, TYPE_ECHO_ALT, addr_b, addr_a, 8'd0, 16'h0000, '0);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_a, addr_b, 8'd50, 16'hA5A5, 32'd10);
		// re-record an address: position kept, TTL and stamp replaced
		add_header(ICMP_PROTOCOL, TYPE_ECHO, addr_a, addr_c, 8'd64, 16'h0F0F, 32'd11);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_c, addr_a, 8'd64, 16'hF0F0, 32'd12);
		// zero source lands in the first empty entry
		add_header(ICMP_PROTOCOL, TYPE_ECHO, '0, addr_a, 8'd65, 16'h3C3C, 32'd13);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_a, '0, 8'd33, 16'hC3C3, 32'd14);
		add_header(ICMP_PROTOCOL, TYPE_ECHO, addr_c, addr_b, 8'd65, 16'h1111, 32'd15);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, addr_c, 8'd2, 16'hFFFE, 32'd16);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, '1, 8'd77, 16'h2222, 32'd16);
		add_header(ICMP_PROTOCOL, TYPE_REPLY, addr_b, '0, 8'd255, 16'hFFFF, 32'd17);

		// more addresses than entries, so the table evicts by stamp
		foreach (addr_pool[i])
			addr_pool[i] = $urandom;
		sim_now = 32'd100;
		for (n = 0; n < N_RANDOM; n++) begin
			roll = $urandom_range(0, 99);
			h.proto = ICMP_PROTOCOL;
			h.src = $urandom;
			h.dst = $urandom;
			h.ttl = 8'($urandom);
			h.csum = 16'($urandom);
			if ($urandom_range(0, 15) == 0)
				sim_now = $urandom;
			else
				sim_now += $urandom_range(0, 3);
			h.now = sim_now;
			if ($urandom_range(0, 1) == 0)
				h.ttl = 8'($urandom_range(0, 70));
			if (roll < 40) begin
				h.icmp = $urandom_range(0, 1) ? TYPE_ECHO : TYPE_ECHO_ALT;
				if ($urandom_range(0, 49) == 0)
					h.src = '0;
				else if ($urandom_range(0, 9) != 0)
					h.src = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else if (roll < 80) begin
				h.icmp = TYPE_REPLY;
				if ($urandom_range(0, 49) == 0)
					h.dst = '0;
				else if ($urandom_range(0, 6) != 0)
					h.dst = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				h.icmp = 8'($urandom);
				if ($urandom_range(0, 1) == 0)
					h.proto = 8'($urandom);
			end
			pending_headers.push_back(h);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_headers.size() != 0 || push)
			@(posedge clk);
		while (expected_rewrites.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* echo_ttl_address_encoder.f */
rtl/core/etae_pkg.sv
rtl/core/etae_ram.sv
rtl/core/etae_front.sv
rtl/core/etae_back.sv
rtl/core/echo_ttl_address_encoder.sv
bench/tb_echo_ttl_address_encoder.sv
